/* rtl/double_ended_queue_core_assert.svh */
// assertion macros of the double-ended queue, used by the sequencer
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define DEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/deq_pkg.sv */
// types and codes of the double-ended queue
package deq_pkg;

	// command codes
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_DUMP       = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam int VALUE_W = 32;

	typedef logic [4:0] fill_t;

	typedef struct packed {
		logic [2:0]                cmd;
		logic signed [VALUE_W-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] out_value;
		logic [1:0]                status;
		logic                      last_of_run;
		fill_t                     fill_count;
	} out_item_t;

endpackage

/* rtl/deq_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/deq_ctrl.sv */
// command sequencer: ring pointers, fill count and ram access for the queue
`include "double_ended_queue_core_assert.svh"

module deq_ctrl #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  deq_pkg::in_item_t              cmd_item,
	output logic                           rslt_valid,
	input  logic                           rslt_ready,
	output deq_pkg::out_item_t             rslt,
	output logic                           ram_we,
	output logic [$clog2(DEPTH)-1:0]       ram_waddr,
	output logic [deq_pkg::VALUE_W-1:0]    ram_wdata,
	output logic                           ram_re,
	output logic [$clog2(DEPTH)-1:0]       ram_raddr,
	input  logic [deq_pkg::VALUE_W-1:0]    ram_rdata
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [IDX_W-1:0] back_q, back_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
	logic             accept;
	logic             full;
	logic             empty;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign cmd_stall = (state_q != S_IDLE) || !rslt_ready;
	assign accept    = cmd_valid && !cmd_stall;

	// command decode, ram access and next state
	always_comb begin
		state_d          = state_q;
		front_d          = front_q;
		back_d           = back_q;
		cnt_d            = cnt_q;
		left_d           = left_q;
		rd_idx_d         = rd_idx_q;
		ram_we           = 1'b0;
		ram_waddr        = back_q;
		ram_wdata        = cmd_item.item_value;
		ram_re           = 1'b0;
		ram_raddr        = front_q;
		rslt_valid       = 1'b0;
		rslt.out_value   = '0;
		rslt.status      = deq_pkg::STAT_OK;
		rslt.last_of_run = 1'b1;
		rslt.fill_count  = deq_pkg::fill_t'(cnt_q);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_item.cmd)
						deq_pkg::CMD_PUSH_BACK, deq_pkg::CMD_PUSH_FRONT: begin
							rslt_valid = 1'b1;
							if (full) begin
								rslt.status = deq_pkg::STAT_FULL;
							end else begin
								ram_we = 1'b1;
								if (cmd_item.cmd == deq_pkg::CMD_PUSH_BACK) begin
									ram_waddr = back_q;
									back_d    = wrap_inc(back_q);
								end else begin
									ram_waddr = wrap_dec(front_q);
									front_d   = wrap_dec(front_q);
								end
								cnt_d           = cnt_q + 1'b1;
								rslt.fill_count = deq_pkg::fill_t'(cnt_q + 1'b1);
							end
						end
						deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
							if (empty) begin
								rslt_valid  = 1'b1;
								rslt.status = deq_pkg::STAT_EMPTY;
							end else begin
								ram_re = 1'b1;
								if (cmd_item.cmd == deq_pkg::CMD_POP_FRONT) begin
									ram_raddr = front_q;
									front_d   = wrap_inc(front_q);
								end else begin
									ram_raddr = wrap_dec(back_q);
									back_d    = wrap_dec(back_q);
								end
								cnt_d   = cnt_q - 1'b1;
								left_d  = CNT_W'(1);
								state_d = S_EMIT;
							end
						end
						deq_pkg::CMD_DUMP: begin
							if (empty) begin
								rslt_valid  = 1'b1;
								rslt.status = deq_pkg::STAT_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = front_q;
								rd_idx_d  = wrap_inc(front_q);
								left_d    = cnt_q;
								state_d   = S_EMIT;
							end
						end
						default: begin
							// unused codes are consumed without a result
						end
					endcase
				end
			end
			S_EMIT: begin
				// registered ram read data goes out; when it is taken, the next read follows at once
				rslt_valid       = 1'b1;
				rslt.out_value   = ram_rdata;
				rslt.last_of_run = (left_q == CNT_W'(1));
				if (rslt_ready) begin
					if (left_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = rd_idx_q;
						rd_idx_d  = wrap_inc(rd_idx_q);
						left_d    = left_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= '0;
			back_q   <= '0;
			cnt_q    <= '0;
			left_q   <= '0;
			rd_idx_q <= '0;
		end else begin
			state_q  <= state_d;
			front_q  <= front_d;
			back_q   <= back_d;
			cnt_q    <= cnt_d;
			left_q   <= left_d;
			rd_idx_q <= rd_idx_d;
		end
	end

	// checks on the sequencer
	`DEQ_ASSERT_IMPLY(a_no_rw_overlap, clk, arst_n, ram_we, !ram_re, "ram read and write overlap")
	`DEQ_ASSERT_IMPLY(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH), "fill count overflow")
	`DEQ_ASSERT_IMPLY(a_ptr_meet, clk, arst_n, empty || full, front_q == back_q, "ring pointers disagree")
	`DEQ_ASSERT_NEXT(a_emit_holds, clk, arst_n, state_q == S_EMIT && !rslt_ready, rslt_valid && $stable(ram_rdata), "pending result lost")

endmodule

/* rtl/double_ended_queue_core.sv */
// top level of the double-ended queue: sequencer, entry ram and result register
//
//  channel | valid     | stall     | payload  | direction
//  command | cmd_valid | cmd_stall | cmd_item | into the block
//  result  | res_valid | res_stall | res_item | out of the block
//
// push: the result goes straight into the result register.
// pop: the ram read is issued first, then the S_EMIT state hands the read data over.
// dump: one ram read per entry, overlapped with the output of the entry before it.
// reset clears pointers, fill count and control; ram contents stay undefined.
// a stalled result holds the sequencer, the ram read data waits in the ram.
module double_ended_queue_core #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  deq_pkg::in_item_t  cmd_item,
	output logic               res_valid,
	input  logic               res_stall,
	output deq_pkg::out_item_t res_item
);

	localparam int IDX_W = $clog2(DEPTH);

	logic                         rslt_valid;
	logic                         rslt_ready;
	deq_pkg::out_item_t           rslt;
	logic                         ram_we;
	logic [IDX_W-1:0]             ram_waddr;
	logic [deq_pkg::VALUE_W-1:0]  ram_wdata;
	logic                         ram_re;
	logic [IDX_W-1:0]             ram_raddr;
	logic [deq_pkg::VALUE_W-1:0]  ram_rdata;
	logic                         res_valid_q;
	deq_pkg::out_item_t           res_item_q;

	deq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_item   (cmd_item),
		.rslt_valid (rslt_valid),
		.rslt_ready (rslt_ready),
		.rslt       (rslt),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	deq_ram #(
		.WIDTH (deq_pkg::VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result register, free when empty or being taken this cycle
	assign rslt_ready = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rslt_ready) begin
			res_valid_q <= rslt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rslt_ready && rslt_valid) begin
			res_item_q <= rslt;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

/* tb/deq_checker.sv */
// checker of the double-ended queue: tracks the queue contents and compares every result
module deq_checker #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  deq_pkg::in_item_t  cmd_item,
	input  logic               res_valid,
	input  logic               res_stall,
	input  deq_pkg::out_item_t res_item,
	output int                 mismatches,
	output int                 outstanding
);

	// shadow of the ring buffer
	logic signed [deq_pkg::VALUE_W-1:0] ring [DEPTH];
	int unsigned front_slot;
	int unsigned back_slot;
	int unsigned held;

	// results still owed by the block, oldest first
	deq_pkg::out_item_t owed_results[$];
	int fail_count = 0;

	function automatic int unsigned slot_after(input int unsigned s);
		return (s + 1 == DEPTH) ? 0 : s + 1;
	endfunction

	function automatic int unsigned slot_before(input int unsigned s);
		return (s == 0) ? DEPTH - 1 : s - 1;
	endfunction

	task automatic owe(input logic signed [deq_pkg::VALUE_W-1:0] value,
			input logic [1:0] code, input logic last);
		deq_pkg::out_item_t r;
		r.out_value   = value;
		r.status      = code;
		r.last_of_run = last;
		r.fill_count  = deq_pkg::fill_t'(held);
		owed_results.insert(owed_results.size(), r);
	endtask

	// work out what one accepted command transaction must produce
	task automatic apply_command(input deq_pkg::in_item_t t);
		logic signed [deq_pkg::VALUE_W-1:0] taken;
		int unsigned s;
		case (t.cmd)
			deq_pkg::CMD_PUSH_BACK, deq_pkg::CMD_PUSH_FRONT: begin
				if (held >= DEPTH) begin
					owe('0, deq_pkg::STAT_FULL, 1'b1);
				end else begin
					if (t.cmd == deq_pkg::CMD_PUSH_BACK) begin
						ring[back_slot] = t.item_value;
						back_slot = slot_after(back_slot);
					end else begin
						front_slot = slot_before(front_slot);
						ring[front_slot] = t.item_value;
					end
					held++;
					owe('0, deq_pkg::STAT_OK, 1'b1);
				end
			end
			deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
				if (held == 0) begin
					owe('0, deq_pkg::STAT_EMPTY, 1'b1);
				end else begin
					if (t.cmd == deq_pkg::CMD_POP_FRONT) begin
						taken = ring[front_slot];
						front_slot = slot_after(front_slot);
					end else begin
						back_slot = slot_before(back_slot);
						taken = ring[back_slot];
					end
					held--;
					owe(taken, deq_pkg::STAT_OK, 1'b1);
				end
			end
			deq_pkg::CMD_DUMP: begin
				if (held == 0) begin
					owe('0, deq_pkg::STAT_EMPTY, 1'b1);
				end else begin
					s = front_slot;
					for (int n = 0; n < held; n++) begin
						owe(ring[s], deq_pkg::STAT_OK, n + 1 == held);
						s = slot_after(s);
					end
				end
			end
			default: ;
		endcase
	endtask

	// compare one result transaction with the oldest owed one
	task automatic check_result(input deq_pkg::out_item_t got);
		deq_pkg::out_item_t want;
		logic bad;
		if (owed_results.size() == 0) begin
			$display("%0t: result with nothing expected: value %0d status %0d last %0b fill %0d",
				$time, got.out_value, got.status, got.last_of_run, got.fill_count);
			fail_count++;
		end else begin
			want = owed_results[0];
			owed_results.delete(0);
			bad = 1'b0;
			if (got.out_value !== want.out_value)     bad = 1'b1;
			if (got.status !== want.status)           bad = 1'b1;
			if (got.last_of_run !== want.last_of_run) bad = 1'b1;
			if (got.fill_count !== want.fill_count)   bad = 1'b1;
			if (bad) begin
				$display({"%0t: mismatch: expected value %0d status %0d last %0b fill %0d,",
					" got value %0d status %0d last %0b fill %0d"},
					$time, want.out_value, want.status, want.last_of_run, want.fill_count,
					got.out_value, got.status, got.last_of_run, got.fill_count);
				fail_count++;
			end
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_results.delete();
			front_slot = 0;
			back_slot  = 0;
			held       = 0;
		end else begin
			if (res_valid && !res_stall)
				check_result(res_item);
			if (cmd_valid && !cmd_stall)
				apply_command(cmd_item);
		end
		outstanding <= owed_results.size();
		mismatches  <= fail_count;
	end

endmodule

/* tb/testbench.sv */
// top of the double-ended queue testbench: clock, reset, command stimulus and verdict
module testbench;

	localparam int DEPTH         = 16;
	localparam int RANDOM_ITEMS  = 110;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 20;

	// command codes the block leaves unused
	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	deq_pkg::in_item_t  cmd_item;
	logic               res_valid;
	logic               res_stall;
	deq_pkg::out_item_t res_item;
	int                 mismatches;
	int                 outstanding;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int holds_wanted  = 0;
	int issued        = 0;

	double_ended_queue_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item (cmd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	deq_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_item   (cmd_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin
		int holds_served;
		holds_served = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_wanted) begin
				holds_served++;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic signed [deq_pkg::VALUE_W-1:0] rand_value();
		case ($urandom_range(9))
			0:       return 32'h7fffffff;
			1:       return 32'h80000000;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [2:0] push_code();
		return $urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK;
	endfunction

	function automatic logic [2:0] pop_code();
		return $urandom_range(1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK;
	endfunction

	// offer one command transaction and wait until it is taken
	task automatic offer(input logic [2:0] code,
			input logic signed [deq_pkg::VALUE_W-1:0] value);
		deq_pkg::in_item_t t;
		t.cmd        = code;
		t.item_value = value;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= t;
		do @(posedge clk); while (cmd_stall);
		issued++;
	endtask

	// mixed run of commands, unused codes now and then
	task automatic mixed_run(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 22)      offer(deq_pkg::CMD_PUSH_BACK, rand_value());
			else if (pick < 40) offer(deq_pkg::CMD_PUSH_FRONT, rand_value());
			else if (pick < 57) offer(deq_pkg::CMD_POP_FRONT, rand_value());
			else if (pick < 74) offer(deq_pkg::CMD_POP_BACK, rand_value());
			else if (pick < 88) offer(deq_pkg::CMD_DUMP, rand_value());
			else offer(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), rand_value());
		end
	endtask

	// stimulus
	initial begin
		int seq;
		int pick;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd_item  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, extremes, only-entry pops, unused codes
		offer(deq_pkg::CMD_POP_FRONT, rand_value());
		offer(deq_pkg::CMD_POP_BACK, rand_value());
		offer(deq_pkg::CMD_DUMP, rand_value());
		offer(CMD_SPARE_LO, rand_value());
		offer(deq_pkg::CMD_PUSH_BACK, 32'h7fffffff);
		offer(deq_pkg::CMD_PUSH_FRONT, 32'h80000000);
		offer(deq_pkg::CMD_DUMP, '0);
		offer(deq_pkg::CMD_POP_BACK, '0);
		offer(deq_pkg::CMD_POP_FRONT, '0);
		offer(deq_pkg::CMD_POP_FRONT, '0);
		offer(deq_pkg::CMD_PUSH_FRONT, '1);
		offer(deq_pkg::CMD_POP_BACK, '0);
		offer(deq_pkg::CMD_DUMP, '0);
		offer(CMD_SPARE_MID, '1);
		offer(CMD_SPARE_HI, 32'h55555555);
		offer(deq_pkg::CMD_PUSH_BACK, '0);
		offer(deq_pkg::CMD_PUSH_FRONT, 32'h55555555);
		offer(deq_pkg::CMD_PUSH_BACK, 32'haaaaaaaa);
		offer(deq_pkg::CMD_DUMP, '0);
		offer(deq_pkg::CMD_POP_FRONT, '0);
		offer(deq_pkg::CMD_POP_BACK, '0);
		offer(deq_pkg::CMD_POP_FRONT, '0);

		// fill to full and beyond, the result side holding off at first
		holds_wanted++;
		repeat (DEPTH + 2) offer(push_code(), rand_value());
		offer(deq_pkg::CMD_DUMP, rand_value());

		// random sequences, idling pattern changing per sequence
		seq = 0;
		while (issued < RANDOM_ITEMS) begin
			case (seq % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 60; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 60; end
				default: begin send_idle_pct = 9; stall_pct = 9; end
			endcase
			pick = $urandom_range(9);
			if (pick < 2) begin
				repeat (DEPTH + 2) offer(push_code(), rand_value());
				offer(deq_pkg::CMD_DUMP, rand_value());
			end else if (pick < 4) begin
				repeat (DEPTH + 2) offer(pop_code(), rand_value());
			end else begin
				mixed_run(8);
			end
			seq++;
		end

		// wait for every owed result, then a little longer
		cmd_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_core.sv
tb/deq_checker.sv
tb/testbench.sv
